// ===== rtl/disc_point_to_hue_offset_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ---------------------------------------------------------------------------
`ifndef DISC_POINT_TO_HUE_OFFSET_TOP_MACROS_SVH
`define DISC_POINT_TO_HUE_OFFSET_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DPHO_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define DPHO_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);
`else
`define DPHO_ASSERT_IMPLY(lbl, ante, cons, msg)
`define DPHO_ASSERT_ALWAYS(lbl, expr, msg)
`endif
`endif

// ===== rtl/dpho_pkg.sv =====
// ---------------------------------------------------------------------------
// Disc point to hue offset package
// Beat types, fixed widths and the CORDIC angle table.
// ---------------------------------------------------------------------------
`default_nettype none

package dpho_pkg;

  localparam int unsigned DATA_WIDTH   = 16;
  localparam int unsigned FRAC_BITS    = DATA_WIDTH - 2;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned CORDIC_W     = 64;
  localparam int unsigned CORDIC_SH    = 60 - DATA_WIDTH;
  localparam int unsigned ANGLE_W      = 32;
  localparam int unsigned HUE_FRAC     = 20;
  localparam int unsigned DEV_W        = HUE_FRAC + 3;
  localparam int unsigned LEN_W        = HUE_FRAC + 2;

  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_coord;
    logic signed [DATA_WIDTH-1:0] y_coord;
    logic signed [DATA_WIDTH-1:0] strength;
  } point_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] delta_red;
    logic signed [DATA_WIDTH-1:0] delta_green;
    logic signed [DATA_WIDTH-1:0] delta_blue;
  } offset_t;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } hue_sector_e;

  function automatic logic [ANGLE_W-1:0] turn_atan(input int unsigned step);
    logic [ANGLE_W-1:0] a;
    case (step)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051D;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2E;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      24: a = 32'h00000028;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000002;
      29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dpho_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// CORDIC vectoring cell
// One rotation step toward the x axis, angle kept in turns.
// ---------------------------------------------------------------------------
`default_nettype none

module dpho_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [dpho_pkg::CORDIC_W-1:0]  x_i,
  input  logic signed [dpho_pkg::CORDIC_W-1:0]  y_i,
  input  logic        [dpho_pkg::ANGLE_W-1:0]   z_i,
  output logic                                  valid_o,
  output logic signed [dpho_pkg::CORDIC_W-1:0]  x_o,
  output logic signed [dpho_pkg::CORDIC_W-1:0]  y_o,
  output logic        [dpho_pkg::ANGLE_W-1:0]   z_o
);

  localparam logic [dpho_pkg::ANGLE_W-1:0] ATAN = dpho_pkg::turn_atan(STEP);

  logic                                 valid_q;
  logic signed [dpho_pkg::CORDIC_W-1:0] x_d, x_q, y_d, y_q, xs, ys;
  logic        [dpho_pkg::ANGLE_W-1:0]  z_d, z_q;

  always_comb begin
    xs = x_i >>> STEP;
    ys = y_i >>> STEP;
    if (!y_i[dpho_pkg::CORDIC_W-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

`default_nettype wire

// ===== rtl/dpho_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// Square root cell
// One result bit of a floor square root, with a side tag carried along.
// ---------------------------------------------------------------------------
`default_nettype none

module dpho_sqrt_cell #(
  parameter int unsigned ROOT_W = 16,
  parameter int unsigned TAG_W  = 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   val_i,
  input  logic [ROOT_W:0]       rem_i,
  input  logic [ROOT_W-1:0]     root_i,
  input  logic [TAG_W-1:0]      tag_i,
  output logic                  valid_o,
  output logic [2*ROOT_W-1:0]   val_o,
  output logic [ROOT_W:0]       rem_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [TAG_W-1:0]      tag_o
);

  logic                  valid_q, ge;
  logic [ROOT_W+1:0]     rad, trial, diff;
  logic [2*ROOT_W-1:0]   val_d, val_q;
  logic [ROOT_W:0]       rem_d, rem_q;
  logic [ROOT_W-1:0]     root_d, root_q;
  logic [TAG_W-1:0]      tag_q;

  always_comb begin
    rad    = {rem_i[ROOT_W-1:0], val_i[2*ROOT_W-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = rad >= trial;
    diff   = rad - trial;
    rem_d  = ge ? diff[ROOT_W:0] : rad[ROOT_W:0];
    root_d = {root_i[ROOT_W-2:0], ge};
    val_d  = {val_i[2*ROOT_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    tag_q  <= tag_i;
  end

  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

// ===== rtl/dpho_div_cell.sv =====
// ---------------------------------------------------------------------------
// Restoring divider cell
// One quotient bit; dividend bits shift out as quotient bits shift in.
// ---------------------------------------------------------------------------
`default_nettype none

module dpho_div_cell #(
  parameter int unsigned QUO_W = 15,
  parameter int unsigned DIV_W = 22,
  parameter int unsigned TAG_W = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [QUO_W-1:0]   nq_i,
  input  logic [DIV_W-1:0]   rem_i,
  input  logic [DIV_W-1:0]   den_i,
  input  logic [TAG_W-1:0]   tag_i,
  output logic               valid_o,
  output logic [QUO_W-1:0]   nq_o,
  output logic [DIV_W-1:0]   rem_o,
  output logic [DIV_W-1:0]   den_o,
  output logic [TAG_W-1:0]   tag_o
);

  logic               valid_q, ge;
  logic [DIV_W:0]     trial, diff;
  logic [QUO_W-1:0]   nq_d, nq_q;
  logic [DIV_W-1:0]   rem_d, rem_q, den_q;
  logic [TAG_W-1:0]   tag_q;

  always_comb begin
    trial = {rem_i, nq_i[QUO_W-1]};
    ge    = trial >= {1'b0, den_i};
    diff  = trial - {1'b0, den_i};
    rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    nq_d  = {nq_i[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    rem_q <= rem_d;
    den_q <= den_i;
    tag_q <= tag_i;
  end

  assign valid_o = valid_q;
  assign nq_o    = nq_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

// ===== rtl/disc_point_to_hue_offset_top.sv =====
// ---------------------------------------------------------------------------
// Disc point to hue offset
// Takes one point and gain per cycle and returns its RGB offset beat on res_o,
// marked by done_o. busy_o stays low, so a new point may be started in every
// cycle and beats leave in the order they came in; the receiver must take each
// beat in its one cycle. The path runs through the 30-cell CORDIC hue chain,
// the 22-cell square root that finds the deviation length and the 15-cell
// divider that normalizes each channel.
// ---------------------------------------------------------------------------
`default_nettype none
`include "disc_point_to_hue_offset_top_macros.svh"

module disc_point_to_hue_offset_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  dpho_pkg::point_t  in_i,
  output logic              done_o,
  output dpho_pkg::offset_t res_o
);

  localparam int unsigned W       = dpho_pkg::DATA_WIDTH;
  localparam int unsigned F       = dpho_pkg::FRAC_BITS;
  localparam int unsigned CW      = dpho_pkg::CORDIC_W;
  localparam int unsigned SH      = dpho_pkg::CORDIC_SH;
  localparam int unsigned AW      = dpho_pkg::ANGLE_W;
  localparam int unsigned NSTEP   = dpho_pkg::CORDIC_STEPS;
  localparam int unsigned HF      = dpho_pkg::HUE_FRAC;
  localparam int unsigned DEV_W   = dpho_pkg::DEV_W;
  localparam int unsigned LEN_W   = dpho_pkg::LEN_W;
  localparam int unsigned C_W     = HF + 1;
  localparam int unsigned H6_W    = AW + 3;
  localparam int unsigned S_W     = W - 1;
  localparam int unsigned P_W     = 2 * W - 2;
  localparam int unsigned QUO_W   = W - 1;
  localparam int unsigned N_W     = QUO_W + LEN_W;
  localparam int unsigned SQ_W    = 2 * LEN_W;
  localparam int unsigned S_DLY   = NSTEP + 3 - W;
  localparam int unsigned LTAG_W  = 3 * DEV_W + S_W;
  localparam int unsigned LAT     = NSTEP + 7 + LEN_W + 2 + QUO_W + 1;

  localparam logic [W-1:0]   ONE_RAD = W'(1) << F;
  localparam logic [P_W-1:0] RND_C   = P_W'(1) << (F - 1);
  localparam logic [C_W-1:0] ONE_HUE = C_W'(1) << HF;

  // stage 1: input
  logic                in_v_q;
  logic signed [W-1:0] in_x_q, in_y_q;
  logic [S_W-1:0]      in_sp_d, in_sp_q;

  // stage 2: radius square and CORDIC entry
  logic                 pre_v_q;
  logic signed [2*W-1:0] sqx_d, sqy_d;
  logic [2*W-1:0]       r2_d, r2_q;
  logic signed [CW-1:0] xe, ye, cx0_d, cx0_q, cy0_d, cy0_q;
  logic [AW-1:0]        cz0_d, cz0_q;
  logic [S_W-1:0]       sp2_q;

  // radius chain
  logic               rv    [W+1];
  logic [2*W-1:0]     rval  [W+1];
  logic [W:0]         rrem  [W+1];
  logic [W-1:0]       rroot [W+1];
  logic [S_W-1:0]     rtag  [W+1];

  // gain
  logic                 rc_v_q, s_v_q;
  logic [S_W-1:0]       rc_d;
  logic [P_W-1:0]       prod_d, prod_q, rnd;
  logic [S_W-1:0]       s_d, s_q;
  logic [S_DLY-1:0]     sdly_v_q;
  logic [S_W-1:0]       sdly_q [S_DLY];

  // hue chain
  logic                 cv [NSTEP+1];
  logic signed [CW-1:0] cx [NSTEP+1];
  logic signed [CW-1:0] cy [NSTEP+1];
  logic [AW-1:0]        cz [NSTEP+1];

  // triple and deviation
  logic                      h6_v_q, dev_v_q, sq_v_q, acc_v_q, len_v_q;
  logic [H6_W-1:0]           h6_d, h6_q;
  dpho_pkg::hue_sector_e     sec;
  logic [C_W-1:0]            fe, fc;
  logic [C_W-1:0]            c [3];
  logic signed [DEV_W-1:0]   ce [3];
  logic signed [DEV_W-1:0]   csum;
  logic signed [DEV_W-1:0]   dev_d [3];
  logic signed [DEV_W-1:0]   dev_q [3];
  logic signed [DEV_W-1:0]   d35_q [3];
  logic signed [DEV_W-1:0]   d36_q [3];
  logic signed [DEV_W-1:0]   d37_q [3];
  logic signed [2*DEV_W-1:0] sqf [3];
  logic [SQ_W-1:0]           sq_q [3];
  logic [SQ_W-1:0]           p01_q, sq2_q, sumsq_q;

  // length chain
  logic               lv    [LEN_W+1];
  logic [SQ_W-1:0]    lval  [LEN_W+1];
  logic [LEN_W:0]     lrem  [LEN_W+1];
  logic [LEN_W-1:0]   lroot [LEN_W+1];
  logic [LTAG_W-1:0]  ltag  [LEN_W+1];

  // normalize
  logic                    mag_v_q, num_v_q;
  logic signed [DEV_W-1:0] ld [3];
  logic [DEV_W-1:0]        lab [3];
  logic [S_W-1:0]          ls;
  logic [N_W-1:0]          mag_d [3];
  logic [N_W-1:0]          mag_q [3];
  logic [N_W-1:0]          num_q [3];
  logic [2:0]              neg60_q, neg61_q;
  logic [LEN_W-1:0]        len60_q, len61_q;

  logic               dv   [3][QUO_W+1];
  logic [QUO_W-1:0]   dnq  [3][QUO_W+1];
  logic [LEN_W-1:0]   drem [3][QUO_W+1];
  logic [LEN_W-1:0]   dden [3][QUO_W+1];
  logic [0:0]         dneg [3][QUO_W+1];

  logic                done_d, done_q;
  logic signed [W-1:0] out_d [3];
  dpho_pkg::offset_t   res_q;

  assign busy_o = 1'b0;

  // stage 1 / 2
  always_comb begin
    in_sp_d = in_i.strength[W-1] ? '0 : in_i.strength[W-2:0];
    sqx_d   = in_x_q * in_x_q;
    sqy_d   = in_y_q * in_y_q;
    r2_d    = $unsigned(sqx_d) + $unsigned(sqy_d);
    xe = $signed({{(CW-W-SH){in_x_q[W-1]}}, in_x_q, {SH{1'b0}}});
    ye = $signed({{(CW-W-SH){in_y_q[W-1]}}, in_y_q, {SH{1'b0}}});
    if (in_x_q[W-1]) begin
      cx0_d = -xe;
      cy0_d = -ye;
      cz0_d = dpho_pkg::HALF_TURN;
    end else begin
      cx0_d = xe;
      cy0_d = ye;
      cz0_d = '0;
    end
  end

  // radius chain
  assign rv[0]    = pre_v_q;
  assign rval[0]  = r2_q;
  assign rrem[0]  = '0;
  assign rroot[0] = '0;
  assign rtag[0]  = sp2_q;

  for (genvar g = 0; g < W; g++) begin : g_rad
    dpho_sqrt_cell #(.ROOT_W(W), .TAG_W(S_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (rv[g]),
      .val_i   (rval[g]),
      .rem_i   (rrem[g]),
      .root_i  (rroot[g]),
      .tag_i   (rtag[g]),
      .valid_o (rv[g+1]),
      .val_o   (rval[g+1]),
      .rem_o   (rrem[g+1]),
      .root_o  (rroot[g+1]),
      .tag_o   (rtag[g+1])
    );
  end

  always_comb begin
    rc_d   = (rroot[W] >= ONE_RAD) ? ONE_RAD[S_W-1:0] : rroot[W][S_W-1:0];
    prod_d = {{(P_W-S_W){1'b0}}, rtag[W]} * {{(P_W-S_W){1'b0}}, rc_d};
    rnd    = prod_q + RND_C;
    s_d    = rnd[F +: S_W];
  end

  // hue chain
  assign cv[0] = pre_v_q;
  assign cx[0] = cx0_q;
  assign cy[0] = cy0_q;
  assign cz[0] = cz0_q;

  for (genvar g = 0; g < NSTEP; g++) begin : g_cordic
    dpho_cordic_cell #(.STEP(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cv[g]),
      .x_i     (cx[g]),
      .y_i     (cy[g]),
      .z_i     (cz[g]),
      .valid_o (cv[g+1]),
      .x_o     (cx[g+1]),
      .y_o     (cy[g+1]),
      .z_o     (cz[g+1])
    );
  end

  always_comb begin
    h6_d = ({3'b000, cz[NSTEP]} << 2) + ({3'b000, cz[NSTEP]} << 1);
    sec  = dpho_pkg::hue_sector_e'(h6_q[AW +: 3]);
    fe   = {1'b0, h6_q[AW-HF +: HF]};
    fc   = ONE_HUE - fe;
    case (sec)
      dpho_pkg::SEC_RED_YEL: begin
        c[0] = ONE_HUE; c[1] = fe;      c[2] = '0;
      end
      dpho_pkg::SEC_YEL_GRN: begin
        c[0] = fc;      c[1] = ONE_HUE; c[2] = '0;
      end
      dpho_pkg::SEC_GRN_CYN: begin
        c[0] = '0;      c[1] = ONE_HUE; c[2] = fe;
      end
      dpho_pkg::SEC_CYN_BLU: begin
        c[0] = '0;      c[1] = fc;      c[2] = ONE_HUE;
      end
      dpho_pkg::SEC_BLU_MAG: begin
        c[0] = fe;      c[1] = '0;      c[2] = ONE_HUE;
      end
      dpho_pkg::SEC_MAG_RED: begin
        c[0] = ONE_HUE; c[1] = '0;      c[2] = fc;
      end
      default: begin
        c[0] = ONE_HUE; c[1] = '0;      c[2] = fc;
      end
    endcase
    for (int k = 0; k < 3; k++) begin
      ce[k] = $signed({{(DEV_W-C_W){1'b0}}, c[k]});
    end
    csum = ce[0] + ce[1] + ce[2];
    for (int k = 0; k < 3; k++) begin
      dev_d[k] = (ce[k] <<< 1) + ce[k] - csum;
      sqf[k]   = dev_q[k] * dev_q[k];
    end
  end

  // length chain
  assign lv[0]    = len_v_q & sdly_v_q[S_DLY-1];
  assign lval[0]  = sumsq_q;
  assign lrem[0]  = '0;
  assign lroot[0] = '0;
  assign ltag[0]  = {d37_q[0], d37_q[1], d37_q[2], sdly_q[S_DLY-1]};

  for (genvar g = 0; g < LEN_W; g++) begin : g_len
    dpho_sqrt_cell #(.ROOT_W(LEN_W), .TAG_W(LTAG_W)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (lv[g]),
      .val_i   (lval[g]),
      .rem_i   (lrem[g]),
      .root_i  (lroot[g]),
      .tag_i   (ltag[g]),
      .valid_o (lv[g+1]),
      .val_o   (lval[g+1]),
      .rem_o   (lrem[g+1]),
      .root_o  (lroot[g+1]),
      .tag_o   (ltag[g+1])
    );
  end

  always_comb begin
    ls = ltag[LEN_W][S_W-1:0];
    for (int k = 0; k < 3; k++) begin
      ld[k]    = $signed(ltag[LEN_W][S_W + (2-k)*DEV_W +: DEV_W]);
      lab[k]   = ld[k][DEV_W-1] ? $unsigned(-ld[k]) : $unsigned(ld[k]);
      mag_d[k] = {{S_W{1'b0}}, lab[k][LEN_W-1:0]} * {{LEN_W{1'b0}}, ls};
    end
  end

  // divider lanes
  for (genvar k = 0; k < 3; k++) begin : g_lane
    assign dv[k][0]   = num_v_q;
    assign dnq[k][0]  = num_q[k][QUO_W-1:0];
    assign drem[k][0] = num_q[k][N_W-1:QUO_W];
    assign dden[k][0] = len61_q;
    assign dneg[k][0] = neg61_q[k];

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
      dpho_div_cell #(.QUO_W(QUO_W), .DIV_W(LEN_W), .TAG_W(1)) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .valid_i (dv[k][j]),
        .nq_i    (dnq[k][j]),
        .rem_i   (drem[k][j]),
        .den_i   (dden[k][j]),
        .tag_i   (dneg[k][j]),
        .valid_o (dv[k][j+1]),
        .nq_o    (dnq[k][j+1]),
        .rem_o   (drem[k][j+1]),
        .den_o   (dden[k][j+1]),
        .tag_o   (dneg[k][j+1])
      );
    end

    assign out_d[k] = dneg[k][QUO_W][0] ? -$signed({1'b0, dnq[k][QUO_W]})
                                        : $signed({1'b0, dnq[k][QUO_W]});
  end

  assign done_d = dv[0][QUO_W] & dv[1][QUO_W] & dv[2][QUO_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      pre_v_q  <= 1'b0;
      rc_v_q   <= 1'b0;
      s_v_q    <= 1'b0;
      sdly_v_q <= '0;
      h6_v_q   <= 1'b0;
      dev_v_q  <= 1'b0;
      sq_v_q   <= 1'b0;
      acc_v_q  <= 1'b0;
      len_v_q  <= 1'b0;
      mag_v_q  <= 1'b0;
      num_v_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_v_q      <= start_i & ~busy_o;
      pre_v_q     <= in_v_q;
      rc_v_q      <= rv[W];
      s_v_q       <= rc_v_q;
      sdly_v_q[0] <= s_v_q;
      for (int i = 1; i < S_DLY; i++) begin
        sdly_v_q[i] <= sdly_v_q[i-1];
      end
      h6_v_q   <= cv[NSTEP];
      dev_v_q  <= h6_v_q;
      sq_v_q   <= dev_v_q;
      acc_v_q  <= sq_v_q;
      len_v_q  <= acc_v_q;
      mag_v_q  <= lv[LEN_W];
      num_v_q  <= mag_v_q;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_x_q    <= in_i.x_coord;
    in_y_q    <= in_i.y_coord;
    in_sp_q   <= in_sp_d;
    r2_q      <= r2_d;
    cx0_q     <= cx0_d;
    cy0_q     <= cy0_d;
    cz0_q     <= cz0_d;
    sp2_q     <= in_sp_q;
    prod_q    <= prod_d;
    s_q       <= s_d;
    sdly_q[0] <= s_q;
    for (int i = 1; i < S_DLY; i++) begin
      sdly_q[i] <= sdly_q[i-1];
    end
    h6_q <= h6_d;
    for (int k = 0; k < 3; k++) begin
      dev_q[k]  <= dev_d[k];
      d35_q[k]  <= dev_q[k];
      d36_q[k]  <= d35_q[k];
      d37_q[k]  <= d36_q[k];
      sq_q[k]   <= sqf[k][SQ_W-1:0];
      mag_q[k]  <= mag_d[k];
      num_q[k]  <= mag_q[k] + {{(N_W-LEN_W+1){1'b0}}, len60_q[LEN_W-1:1]};
    end
    p01_q   <= sq_q[0] + sq_q[1];
    sq2_q   <= sq_q[2];
    sumsq_q <= p01_q + sq2_q;
    for (int k = 0; k < 3; k++) begin
      neg60_q[k] <= ld[k][DEV_W-1];
    end
    len60_q <= lroot[LEN_W];
    neg61_q <= neg60_q;
    len61_q <= len60_q;
    res_q.delta_red   <= out_d[0];
    res_q.delta_green <= out_d[1];
    res_q.delta_blue  <= out_d[2];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `DPHO_ASSERT_ALWAYS(a_gain_align, len_v_q == sdly_v_q[S_DLY-1], "gain and hue beats misaligned")
  `DPHO_ASSERT_IMPLY(a_latency, done_o, $past(start_i & ~busy_o, LAT), "result without a start")
  `DPHO_ASSERT_IMPLY(a_start_done, start_i & ~busy_o, ##LAT done_o, "start without a result")
  `DPHO_ASSERT_IMPLY(a_no_gain, done_o && $past(in_i.strength[W-1], LAT), res_o == '0, "negative gain gave an offset")
  `DPHO_ASSERT_IMPLY(a_origin, done_o && $past(in_i.x_coord == '0 && in_i.y_coord == '0, LAT), res_o == '0, "origin gave an offset")

endmodule

`default_nettype wire

// ===== dv/disc_point_to_hue_offset_top_tb.sv =====
// ---------------------------------------------------------------------------
// Disc point to hue offset testbench
// Drives points and gains through the command port, predicts each RGB offset
// beat with a fixed-point model of radius, CORDIC hue, sector triple and
// normalized deviation, and checks every done_o beat against it in order.
// ---------------------------------------------------------------------------
`default_nettype none

module disc_point_to_hue_offset_top_tb;

  localparam int LATENCY = 77;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  dpho_pkg::point_t in_i = '0;
  logic done_o;
  dpho_pkg::offset_t res_o;

  dpho_pkg::offset_t offset_q[$];
  int errors = 0;
  int send_idle_pct = 0;

  disc_point_to_hue_offset_top uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .in_i(in_i), .done_o(done_o), .res_o(res_o)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #20000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [31:0] hue_angle(longint x, longint y);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    x = x <<< dpho_pkg::CORDIC_SH;
    y = y <<< dpho_pkg::CORDIC_SH;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = dpho_pkg::HALF_TURN;
    end
    for (int i = 0; i < dpho_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += dpho_pkg::turn_atan(i);
      end else begin
        x -= ys; y += xs; z -= dpho_pkg::turn_atan(i);
      end
    end
    return z;
  endfunction

  function automatic logic signed [15:0] sat16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic dpho_pkg::offset_t hue_offset(dpho_pkg::point_t p);
    longint x, y, st, one, rc, c0, f, sum, len, s, mag, q;
    longint c[3], d[3], v[3];
    logic [63:0] h6;
    dpho_pkg::hue_sector_e sec;
    dpho_pkg::offset_t o;
    x = p.x_coord; y = p.y_coord; st = p.strength;
    one = 64'd1 << dpho_pkg::FRAC_BITS;
    c0 = 64'd1 << dpho_pkg::HUE_FRAC;
    rc = int_sqrt(x * x + y * y);
    if (rc > one) rc = one;
    h6 = {32'd0, hue_angle(x, y)} * 64'd6;
    f = h6[31:0] >> (32 - dpho_pkg::HUE_FRAC);
    sec = dpho_pkg::hue_sector_e'(h6[34:32]);
    case (sec)
      dpho_pkg::SEC_RED_YEL: begin c[0] = c0;     c[1] = f;      c[2] = 0;      end
      dpho_pkg::SEC_YEL_GRN: begin c[0] = c0 - f; c[1] = c0;     c[2] = 0;      end
      dpho_pkg::SEC_GRN_CYN: begin c[0] = 0;      c[1] = c0;     c[2] = f;      end
      dpho_pkg::SEC_CYN_BLU: begin c[0] = 0;      c[1] = c0 - f; c[2] = c0;     end
      dpho_pkg::SEC_BLU_MAG: begin c[0] = f;      c[1] = 0;      c[2] = c0;     end
      default:               begin c[0] = c0;     c[1] = 0;      c[2] = c0 - f; end
    endcase
    sum = c[0] + c[1] + c[2];
    for (int k = 0; k < 3; k++) d[k] = 3 * c[k] - sum;
    len = int_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]);
    if (len == 0) len = 1;
    s = ((st > 0 ? st : 0) * rc + (64'd1 << (dpho_pkg::FRAC_BITS - 1)))
        >> dpho_pkg::FRAC_BITS;
    for (int k = 0; k < 3; k++) begin
      mag = (d[k] < 0 ? -d[k] : d[k]) * s;
      q = (mag + len / 2) / len;
      v[k] = d[k] < 0 ? -q : q;
    end
    o.delta_red = sat16(v[0]);
    o.delta_green = sat16(v[1]);
    o.delta_blue = sat16(v[2]);
    return o;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) offset_q.push_back(hue_offset(in_i));
    if (rst_ni && done_o) begin
      if (offset_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, res_o);
        errors++;
      end else begin
        dpho_pkg::offset_t e;
        e = offset_q.pop_front();
        if (e.delta_red !== res_o.delta_red || e.delta_green !== res_o.delta_green
            || e.delta_blue !== res_o.delta_blue) begin
          $display("%0t: mismatch, expected %h actual %h", $time, e, res_o);
          errors++;
        end
      end
    end
  end

  task automatic send_point(dpho_pkg::point_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i <= p;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (offset_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return $signed(16'($urandom_range(32767))) - 16'sd16384;
      2: return $signed(16'($urandom_range(2047))) - 16'sd1024;
      default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  typedef struct {
    dpho_pkg::point_t pt;
    logic has_exp;
    dpho_pkg::offset_t exp_off;
  } dir_row_t;

  dir_row_t dir_rows[$];

  task automatic add_row(int x, int y, int s, logic he, int r, int g, int b);
    dir_row_t row;
    row.pt = '{x_coord: 16'(x), y_coord: 16'(y), strength: 16'(s)};
    row.has_exp = he;
    row.exp_off = '{delta_red: 16'(r), delta_green: 16'(g), delta_blue: 16'(b)};
    dir_rows.push_back(row);
  endtask

  initial begin
    dpho_pkg::point_t p;
    // origin, negative and zero strength give zero; others use predictor
    add_row(0, 0, 16384, 1, 0, 0, 0);
    add_row(0, 0, 32767, 1, 0, 0, 0);
    add_row(16384, 0, -1, 1, 0, 0, 0);
    add_row(-32768, -32768, -32768, 1, 0, 0, 0);
    add_row(32767, 32767, -16384, 1, 0, 0, 0);
    add_row(16384, 0, 16384, 0, 0, 0, 0);
    add_row(-16384, 0, 16384, 0, 0, 0, 0);
    add_row(0, 16384, 16384, 0, 0, 0, 0);
    add_row(0, -16384, 16384, 0, 0, 0, 0);
    add_row(32767, 32767, 32767, 0, 0, 0, 0);
    add_row(-32768, -32768, 32767, 0, 0, 0, 0);
    add_row(-32768, 32767, 32767, 0, 0, 0, 0);
    add_row(32767, -32768, 32767, 0, 0, 0, 0);
    add_row(8192, 14189, 32767, 0, 0, 0, 0);
    add_row(-8192, 14189, 20000, 0, 0, 0, 0);
    add_row(-8192, -14189, 20000, 0, 0, 0, 0);
    add_row(8192, -14189, 20000, 0, 0, 0, 0);
    add_row(1, 0, 32767, 0, 0, 0, 0);
    add_row(0, -1, 32767, 0, 0, 0, 0);
    add_row(-1, -1, 1, 0, 0, 0, 0);
    add_row(4000, 3000, 0, 1, 0, 0, 0);
    add_row(10, -32768, 32767, 0, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp && dir_rows[i].exp_off !== hue_offset(dir_rows[i].pt)) begin
        $display("%0t: mismatch, expected %h actual %h", $time,
                 dir_rows[i].exp_off, hue_offset(dir_rows[i].pt));
        errors++;
      end
      send_point(dir_rows[i].pt);
    end
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 56 : 0;
      for (int n = 0; n < 200; n++) begin
        p.x_coord = rand_coord();
        p.y_coord = rand_coord();
        p.strength = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                     : 16'($urandom_range(32767));
        send_point(p);
        if (n == 100) drain();
      end
    end

    drain();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
